// ----- rtl/sst_pkg.sv -----
// Shared types, sizes and codes for the sorted sparse term accumulator.
// No dependencies; imported by every module of the block.
package sst_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IDXC_W    = IDX_W + 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int RIDX_W    = 6;
    localparam int RCMP_W    = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;
    localparam int GROUP     = 8;
    localparam int NGROUP    = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_COMBINED  = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_ZERO      = 3'd3,
        ST_FULL      = 3'd4,
        ST_READ_OK   = 3'd5,
        ST_READ_OOR  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INS,
        ACT_UPD,
        ACT_DEL
    } act_t;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] coeff;
        logic [15:0]        exp_first;
        logic [15:0]        exp_second;
        logic [5:0]         read_index;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic [6:0]         term_count;
        logic               is_empty;
        logic signed [31:0] out_coeff;
        logic [15:0]        out_exp_first;
        logic [15:0]        out_exp_second;
    } out_t;

    typedef struct packed {
        logic signed [31:0] coeff;
        logic [15:0]        ef;
        logic [15:0]        es;
    } term_t;

    typedef struct packed {
        logic  hit;
        logic  zero;
        term_t term;
    } red_t;

    typedef struct packed {
        logic              cmp;
        logic              apply;
        act_t              act;
        logic              rd;
        term_t             key;
        logic [RIDX_W-1:0] ridx;
        logic [CNT_W-1:0]  count;
    } ctl_t;

endpackage

// ----- rtl/sorted_sparse_term_accumulator_top.sv -----
// Top level of the sorted sparse term accumulator: control sequencer,
// chain of term cells and result collection. Depends on sst_pkg, sst_cell, sst_reduce.
//
// Usage:
//   s_valid/s_ready/s_data carry one request transaction (insert/accumulate
//   or read). m_valid/m_ready/m_data carry exactly one result per request.
//   Each request passes through these steps in order: accept, per-cell key
//   compare and saturating add, registered group OR of the selected cell,
//   then the decision, which updates or shifts every cell at once and loads
//   the output register. A new request is accepted only once the previous
//   one has left the decision step and loaded the output register.
//   If the output register still holds an untaken result, the decision
//   step waits until m_ready frees it; a new request can be accepted while
//   a result waits. Reset (aresetn low at a clock edge) empties the table
//   and drops any result in flight; no clearing pass is needed, stored
//   terms above the count are never read.
module sorted_sparse_term_accumulator_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sst_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sst_pkg::out_t  m_data
);
    import sst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_RES
    } state_t;

    state_t           state_reg, state_next;
    in_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    ctl_t             ctl;
    red_t             red;
    act_t             act;
    out_t             res;
    logic [CNT_W-1:0] res_count;
    logic             out_free;
    logic             full;
    logic [CNT_W+6:0] cnt_ext;

    term_t            cell_term [CAPACITY];
    red_t             cell_red  [CAPACITY];
    logic [CAPACITY-1:0] cell_less;
    logic [CAPACITY-1:0] cell_hit;

    assign out_free = !m_valid_reg || m_ready;
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign s_ready  = state_reg == S_IDLE;

    assign ctl.cmp       = state_reg == S_CMP;
    assign ctl.apply     = (state_reg == S_RES) && out_free;
    assign ctl.act       = act;
    assign ctl.rd        = cmd_reg.operation == OP_READ;
    assign ctl.key.coeff = cmd_reg.coeff;
    assign ctl.key.ef    = cmd_reg.exp_first;
    assign ctl.key.es    = cmd_reg.exp_second;
    assign ctl.ridx      = cmd_reg.read_index;
    assign ctl.count     = count_reg;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic  prev_less;
        term_t left_term;
        term_t right_term;

        if (i == 0) begin : g_first
            assign prev_less = 1'b1;
            assign left_term = ctl.key;
        end else begin : g_inner
            assign prev_less = cell_less[i-1];
            assign left_term = cell_term[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_term = cell_term[i];
        end else begin : g_body
            assign right_term = cell_term[i+1];
        end

        sst_cell u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .cell_idx   (IDX_W'(i)),
            .prev_less  (prev_less),
            .left_term  (left_term),
            .right_term (right_term),
            .term       (cell_term[i]),
            .less       (cell_less[i]),
            .red        (cell_red[i])
        );

        assign cell_hit[i] = cell_red[i].hit;
    end

    sst_reduce u_reduce (
        .aclk     (aclk),
        .cell_red (cell_red),
        .result   (red)
    );

    always_comb begin
        act            = ACT_NONE;
        res_count      = count_reg;
        res.status     = ST_ZERO;
        res.out_coeff  = 32'sd0;
        res.out_exp_first  = 16'd0;
        res.out_exp_second = 16'd0;
        if (ctl.rd) begin
            if (red.hit) begin
                res.status         = ST_READ_OK;
                res.out_coeff      = red.term.coeff;
                res.out_exp_first  = red.term.ef;
                res.out_exp_second = red.term.es;
            end else begin
                res.status = ST_READ_OOR;
            end
        end else if (cmd_reg.coeff == 32'sd0) begin
            res.status = ST_ZERO;
        end else if (red.hit && !red.zero) begin
            act                = ACT_UPD;
            res.status         = ST_COMBINED;
            res.out_coeff      = red.term.coeff;
            res.out_exp_first  = cmd_reg.exp_first;
            res.out_exp_second = cmd_reg.exp_second;
        end else if (red.hit) begin
            act                = ACT_DEL;
            res_count          = count_reg - CNT_W'(1);
            res.status         = ST_CANCELLED;
            res.out_exp_first  = cmd_reg.exp_first;
            res.out_exp_second = cmd_reg.exp_second;
        end else begin
            if (!full) begin
                act        = ACT_INS;
                res_count  = count_reg + CNT_W'(1);
                res.status = ST_INSERTED;
            end else begin
                res.status = ST_FULL;
            end
            res.out_coeff      = cmd_reg.coeff;
            res.out_exp_first  = cmd_reg.exp_first;
            res.out_exp_second = cmd_reg.exp_second;
        end
        cnt_ext        = {7'd0, res_count};
        res.term_count = cnt_ext[6:0];
        res.is_empty   = res_count == '0;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data;
                    state_next = S_CMP;
                end
            end
            S_CMP: state_next = S_RED;
            S_RED: state_next = S_RES;
            S_RES: begin
                if (out_free) begin
                    count_next   = res_count;
                    m_valid_next = 1'b1;
                    m_data_next  = res;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("term count above capacity");

    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RES) |-> $onehot0(cell_hit))
        else $error("more than one cell selected");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.apply && act == ACT_INS) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the table");

    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.apply && act == ACT_DEL) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("removal did not shrink the table");
`endif

endmodule

// ----- rtl/sst_cell.sv -----
// One slot of the sorted term chain: compares its term with the broadcast key,
// then keeps, updates or shifts from a neighbor. Depends on sst_pkg.
module sst_cell (
    input  logic                        aclk,
    input  sst_pkg::ctl_t               ctl,
    input  logic [sst_pkg::IDX_W-1:0]   cell_idx,
    input  logic                        prev_less,
    input  sst_pkg::term_t              left_term,
    input  sst_pkg::term_t              right_term,
    output sst_pkg::term_t              term,
    output logic                        less,
    output sst_pkg::red_t               red
);
    import sst_pkg::*;

    term_t              term_reg, term_next;
    logic               less_reg;
    logic               sel_reg;
    logic signed [31:0] sum_reg;

    logic               valid;
    logic               key_less;
    logic               key_eq;
    logic               idx_eq;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic               at_pos;
    logic               after_pos;

    assign valid    = {1'b0, cell_idx} < IDXC_W'(ctl.count);
    assign key_less = (term_reg.ef < ctl.key.ef) ||
                      ((term_reg.ef == ctl.key.ef) && (term_reg.es < ctl.key.es));
    assign key_eq   = (term_reg.ef == ctl.key.ef) && (term_reg.es == ctl.key.es);
    assign idx_eq   = RCMP_W'(cell_idx) == RCMP_W'(ctl.ridx);

    assign sum_wide = {term_reg.coeff[31], term_reg.coeff} + {ctl.key.coeff[31], ctl.key.coeff};
    always_comb begin
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sum_sat = sum_wide[31:0];
        end
    end

    assign at_pos    = !less_reg && prev_less;
    assign after_pos = !less_reg && !prev_less;

    always_comb begin
        term_next = term_reg;
        if (ctl.apply) begin
            case (ctl.act)
                ACT_INS: begin
                    if (at_pos) begin
                        term_next = ctl.key;
                    end else if (after_pos) begin
                        term_next = left_term;
                    end
                end
                ACT_UPD: begin
                    if (sel_reg) begin
                        term_next.coeff = sum_reg;
                    end
                end
                ACT_DEL: begin
                    if (at_pos || after_pos) begin
                        term_next = right_term;
                    end
                end
                default: term_next = term_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        term_reg <= term_next;
        if (ctl.cmp) begin
            less_reg <= valid && key_less;
            sel_reg  <= valid && (ctl.rd ? idx_eq : key_eq);
            sum_reg  <= sum_sat;
        end
    end

    always_comb begin
        red = '0;
        if (sel_reg) begin
            red.hit  = 1'b1;
            red.zero = !ctl.rd && (sum_reg == 32'sd0);
            red.term = ctl.rd ? term_reg
                              : term_t'{coeff: sum_reg, ef: term_reg.ef, es: term_reg.es};
        end
    end

    assign term = term_reg;
    assign less = less_reg;

endmodule

// ----- rtl/sst_reduce.sv -----
// Two-level OR tree that collects the single selected cell's record.
// Group ORs are registered; the final OR is combinational. Depends on sst_pkg.
module sst_reduce (
    input  logic           aclk,
    input  sst_pkg::red_t  cell_red [sst_pkg::CAPACITY],
    output sst_pkg::red_t  result
);
    import sst_pkg::*;

    red_t grp_reg  [NGROUP];
    red_t grp_next [NGROUP];

    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP; k++) begin
                if (g * GROUP + k < CAPACITY) begin
                    grp_next[g] = grp_next[g] | cell_red[g * GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
    end

    always_comb begin
        result = '0;
        for (int g = 0; g < NGROUP; g++) begin
            result = result | grp_reg[g];
        end
    end

endmodule

// ----- test/term_table_checker.sv -----
`timescale 1ns / 100ps
// Checker for the sorted sparse term accumulator: keeps its own term table,
// predicts one result per accepted request and compares each returned transaction.
// Depends on sst_pkg.
module term_table_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  sst_pkg::in_t   s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  sst_pkg::out_t  m_data,
    output int             fail_count,
    output int             pending
);
    import sst_pkg::*;

    localparam longint SUM_MAX = 2147483647;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    logic signed [31:0] tbl_coeff [CAPACITY];
    logic [15:0]        tbl_ef    [CAPACITY];
    logic [15:0]        tbl_es    [CAPACITY];
    int                 tbl_count = 0;
    out_t               expected_q [$];
    int                 mismatches = 0;
    int                 backlog = 0;

    assign fail_count = mismatches;
    assign pending    = backlog;

    function automatic out_t fold_term(in_t req);
        out_t   res;
        int     pos;
        longint sum;
        res = '0;
        if (req.operation == OP_READ) begin
            if (int'(req.read_index) < tbl_count) begin
                res.status         = ST_READ_OK;
                res.out_coeff      = tbl_coeff[req.read_index];
                res.out_exp_first  = tbl_ef[req.read_index];
                res.out_exp_second = tbl_es[req.read_index];
            end else begin
                res.status = ST_READ_OOR;
            end
        end else if (req.coeff == 0) begin
            res.status = ST_ZERO;
        end else begin
            pos = 0;
            while (pos < tbl_count &&
                   {tbl_ef[pos], tbl_es[pos]} < {req.exp_first, req.exp_second})
                pos++;
            res.out_exp_first  = req.exp_first;
            res.out_exp_second = req.exp_second;
            if (pos < tbl_count && tbl_ef[pos] == req.exp_first &&
                tbl_es[pos] == req.exp_second) begin
                sum = longint'($signed(tbl_coeff[pos])) + longint'($signed(req.coeff));
                if (sum > SUM_MAX) sum = SUM_MAX;
                if (sum < SUM_MIN) sum = SUM_MIN;
                if (sum != 0) begin
                    tbl_coeff[pos] = sum[31:0];
                    res.status     = ST_COMBINED;
                    res.out_coeff  = sum[31:0];
                end else begin
                    for (int k = pos + 1; k < tbl_count; k++) begin
                        tbl_coeff[k-1] = tbl_coeff[k];
                        tbl_ef[k-1]    = tbl_ef[k];
                        tbl_es[k-1]    = tbl_es[k];
                    end
                    tbl_count--;
                    res.status = ST_CANCELLED;
                end
            end else if (tbl_count >= CAPACITY) begin
                res.status    = ST_FULL;
                res.out_coeff = req.coeff;
            end else begin
                for (int k = tbl_count; k > pos; k--) begin
                    tbl_coeff[k] = tbl_coeff[k-1];
                    tbl_ef[k]    = tbl_ef[k-1];
                    tbl_es[k]    = tbl_es[k-1];
                end
                tbl_coeff[pos] = req.coeff;
                tbl_ef[pos]    = req.exp_first;
                tbl_es[pos]    = req.exp_second;
                tbl_count++;
                res.status    = ST_INSERTED;
                res.out_coeff = req.coeff;
            end
        end
        res.term_count = tbl_count[6:0];
        res.is_empty   = (tbl_count == 0);
        return res;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            tbl_count = 0;
            expected_q.delete();
            backlog <= 0;
        end else begin
            // retire before queuing: a returned transaction always belongs to an older request
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none actual %h", $time, m_data);
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", 32'(want.status), 32'(m_data.status));
                    check_field("term_count", 32'(want.term_count),
                                32'(m_data.term_count));
                    check_field("is_empty", 32'(want.is_empty), 32'(m_data.is_empty));
                    check_field("out_coeff", want.out_coeff, m_data.out_coeff);
                    check_field("out_exp_first", 32'(want.out_exp_first),
                                32'(m_data.out_exp_first));
                    check_field("out_exp_second", 32'(want.out_exp_second),
                                32'(m_data.out_exp_second));
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(fold_term(s_data));
            backlog <= expected_q.size();
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Top of the term accumulator testbench: clock, reset, bursty request traffic,
// stalling result sink and the final verdict.
// Depends on sst_pkg, sorted_sparse_term_accumulator_top and term_table_checker.
module tb;
    import sst_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 128;
    localparam int LONG_HOLD   = 300;
    localparam int COEF_SMALL   = 0;
    localparam int COEF_ANY     = 1;
    localparam int COEF_EXTREME = 2;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   hold_request = 1'b0;

    logic [15:0] pool_ef [POOL_SIZE];
    logic [15:0] pool_es [POOL_SIZE];

    sorted_sparse_term_accumulator_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    term_table_checker term_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // result sink: random stall modes, plus one long hold-off on request
    initial begin
        int stall_left;
        int mode;
        int mode_left;
        stall_left = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic offer(in_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause(int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic in_t mk(logic op, logic [31:0] coeff, logic [15:0] ef,
                               logic [15:0] es, logic [5:0] ridx);
        in_t req;
        req.operation  = op;
        req.coeff      = coeff;
        req.exp_first  = ef;
        req.exp_second = es;
        req.read_index = ridx;
        if (op == OP_READ) begin
            req.coeff      = $urandom;
            req.exp_first  = 16'($urandom);
            req.exp_second = 16'($urandom);
        end else begin
            req.read_index = 6'($urandom_range(0, 63));
        end
        return req;
    endfunction

    // pool_used == 0 means fully random exponents
    function automatic in_t make_request(int pool_used, int coeff_kind, int read_pct);
        in_t req;
        int  slot;
        int  mag;
        req.operation  = ($urandom_range(0, 99) < read_pct) ? OP_READ : OP_INSERT;
        req.read_index = 6'($urandom_range(0, 63));
        if (pool_used == 0) begin
            req.exp_first  = 16'($urandom);
            req.exp_second = 16'($urandom);
        end else begin
            slot = $urandom_range(0, pool_used - 1);
            req.exp_first  = pool_ef[slot];
            req.exp_second = pool_es[slot];
        end
        case (coeff_kind)
            COEF_SMALL: begin
                mag = $urandom_range(1, 3);
                req.coeff = ($urandom_range(0, 1) == 1) ? -mag : mag;
                if ($urandom_range(0, 19) == 0) req.coeff = 0;
            end
            COEF_EXTREME: begin
                case ($urandom_range(0, 5))
                    0: req.coeff = 32'h7FFF_FFFF;
                    1: req.coeff = 32'h8000_0000;
                    2: req.coeff = 32'h8000_0001;
                    3: req.coeff = 32'h0000_0001;
                    4: req.coeff = 32'hFFFF_FFFF;
                    default: req.coeff = $urandom;
                endcase
            end
            default: begin
                req.coeff = $urandom;
                if ($urandom_range(0, 29) == 0) req.coeff = 0;
            end
        endcase
        return req;
    endfunction

    task automatic run_phase(int items, int pool_used, int coeff_kind, int read_pct,
                             bit long_hold);
        int sent;
        int burst;
        int hold_at;
        sent = 0;
        hold_at = long_hold ? $urandom_range(items / 4, items / 2) : -1;
        while (sent < items) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < items) begin
                if (sent == hold_at) hold_request = 1'b1;
                offer(make_request(pool_used, coeff_kind, read_pct));
                sent++;
                burst--;
            end
            pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        drain();
    endtask

    initial begin
        pool_ef[0] = 16'h0000; pool_es[0] = 16'h0000;
        pool_ef[1] = 16'hFFFF; pool_es[1] = 16'hFFFF;
        pool_ef[2] = 16'h0000; pool_es[2] = 16'hFFFF;
        pool_ef[3] = 16'hFFFF; pool_es[3] = 16'h0000;
        for (int i = 4; i < POOL_SIZE; i++) begin
            pool_ef[i] = (i % 2 == 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            pool_es[i] = 16'($urandom);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        offer(mk(OP_READ,   32'h0,         16'h0,    16'h0,    6'd0));
        offer(mk(OP_INSERT, 32'h0,         16'hFFFF, 16'h0001, 6'd0));
        offer(mk(OP_INSERT, 32'd7,         16'd5,    16'd5,    6'd0));
        offer(mk(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 6'd0));
        offer(mk(OP_INSERT, 32'h8000_0000, 16'h0000, 16'h0000, 6'd0));
        offer(mk(OP_INSERT, -32'sd3,       16'd5,    16'd2,    6'd0));
        offer(mk(OP_INSERT, 32'd9,         16'd5,    16'hFFFF, 6'd0));
        offer(mk(OP_INSERT, 32'd1,         16'hFFFF, 16'hFFFF, 6'd0));
        offer(mk(OP_INSERT, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 6'd0));
        offer(mk(OP_INSERT, -32'sd7,       16'd5,    16'd5,    6'd0));
        offer(mk(OP_INSERT, 32'd4,         16'hFFFF, 16'h0000, 6'd0));
        offer(mk(OP_INSERT, 32'd2,         16'd5,    16'd2,    6'd0));
        for (int i = 0; i < 6; i++)
            offer(mk(OP_READ, 32'h0, 16'h0, 16'h0, 6'(i)));
        offer(mk(OP_READ,   32'h0,         16'h0,    16'h0,    6'd63));
        offer(mk(OP_INSERT, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 6'd0));
        offer(mk(OP_INSERT, 32'd1,         16'hFFFF, 16'hFFFF, 6'd0));
        offer(mk(OP_READ,   32'h0,         16'h0,    16'h0,    6'd4));
        drain();

        run_phase(450, 6,   COEF_SMALL,   25, 1'b0);
        run_phase(500, 100, COEF_ANY,     15, 1'b1);
        run_phase(450, 80,  COEF_EXTREME, 15, 1'b0);
        run_phase(400, 0,   COEF_ANY,     30, 1'b1);

        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
